/* rtl/swmc_pkg.sv */
// Shared constants and types for the stack with match count and remove.
`default_nettype none

package swmc_pkg;

  // Stored word width and width of the count fields on the result channel
  localparam int unsigned DATA_W = 32;
  localparam int unsigned RES_W  = 7;

  // Operation codes carried on the input channel
  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_COUNT  = 2'd1,
    MODE_REMOVE = 2'd2
  } mode_e;

endpackage

`default_nettype wire

/* rtl/swmc_ram.sv */
// Simple dual-port entry memory: one write port, one read port, registered read data.
`default_nettype none

module swmc_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [AW-1:0]               waddr_i,
  input  wire logic [swmc_pkg::DATA_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [AW-1:0]               raddr_i,
  output logic      [swmc_pkg::DATA_W-1:0] rdata_o
);
  import swmc_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  // Write the addressed entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read of the addressed entry
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/stack_with_match_count_and_remove.sv */
// Top level: bounded LIFO stack with match count and topmost-match removal.
//
//   channel  | handshake              | payload
//   ---------+------------------------+---------------------------------------------
//   input    | in_valid_i/in_ready_o  | mode_i, value_i
//   result   | out_valid_o/out_ready_i| match_count_o, found_o, overflow_o, fill_level_o
//
// Push and the unused code go straight to the result state; count and remove scan every
// held entry, and remove then moves each entry above the topmost match down by one place.
// One memory read per cycle sets the scan and the shift-down. Reset clears the state, the
// entry count, the read-valid flag and the output valid; the memory is not cleared.
// A result waiting on out_ready_i holds the sequencer, while one further transaction may
// already be accepted.
`default_nettype none

module stack_with_match_count_and_remove #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [1:0]                  mode_i,
  input  wire logic signed [swmc_pkg::DATA_W-1:0] value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic [swmc_pkg::RES_W-1:0]       match_count_o,
  output logic                             found_o,
  output logic                             overflow_o,
  output logic [swmc_pkg::RES_W-1:0]       fill_level_o
);
  import swmc_pkg::*;

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_SHIFT  = 5'b00100,
    ST_RESULT = 5'b01000,
    ST_SPARE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CW-1:0]            count_q, count_d;
  logic [CW-1:0]            hits_q, hits_d;
  logic [CW-1:0]            rd_idx_q, rd_idx_d;
  logic [AW-1:0]            cmp_idx_q, cmp_idx_d;
  logic [AW-1:0]            top_q, top_d;
  logic                     rd_vld_q, rd_vld_d;
  logic                     ovf_q, ovf_d;
  logic                     remove_q, remove_d;
  logic signed [DATA_W-1:0] value_q, value_d;

  logic                     out_valid_q, out_valid_d;
  logic [RES_W-1:0]         match_count_q, match_count_d;
  logic                     found_q, found_d;
  logic                     overflow_q, overflow_d;
  logic [RES_W-1:0]         fill_level_q, fill_level_d;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  logic [DATA_W-1:0]        ram_wdata;
  logic                     ram_re;
  logic [AW-1:0]            ram_raddr;
  logic [DATA_W-1:0]        ram_rdata;

  logic                     in_fire;
  logic                     issue;
  logic                     hit;

  swmc_ram #(
    .DEPTH (STACK_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign issue      = (rd_idx_q < count_q);
  assign hit        = rd_vld_q && (ram_rdata == DATA_W'(value_q));

  // Sequence push, scan, shift-down and result hand-off
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    hits_d        = hits_q;
    rd_idx_d      = rd_idx_q;
    cmp_idx_d     = cmp_idx_q;
    top_d         = top_q;
    rd_vld_d      = 1'b0;
    ovf_d         = ovf_q;
    remove_d      = remove_q;
    value_d       = value_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    match_count_d = match_count_q;
    found_d       = found_q;
    overflow_d    = overflow_q;
    fill_level_d  = fill_level_q;
    ram_we        = 1'b0;
    ram_waddr     = count_q[AW-1:0];
    ram_wdata     = DATA_W'(value_i);
    ram_re        = 1'b0;
    ram_raddr     = rd_idx_q[AW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          value_d  = value_i;
          hits_d   = '0;
          ovf_d    = 1'b0;
          remove_d = 1'b0;
          rd_idx_d = '0;
          unique case (mode_e'(mode_i))
            MODE_PUSH: begin
              // Write on top, or drop and flag when full
              if (count_q == CW'(STACK_DEPTH)) begin
                ovf_d = 1'b1;
              end else begin
                ram_we  = 1'b1;
                count_d = count_q + CW'(1);
              end
              state_d = ST_RESULT;
            end
            MODE_COUNT: begin
              state_d = ST_SCAN;
            end
            MODE_REMOVE: begin
              remove_d = 1'b1;
              state_d  = ST_SCAN;
            end
            default: begin
              state_d = ST_RESULT;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle and compare the returning word
        if (issue) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[AW-1:0];
        end
        if (hit) begin
          hits_d = hits_q + CW'(1);
          top_d  = cmp_idx_q;
        end
        if (!issue && !rd_vld_q) begin
          if (remove_q && (hits_q != '0)) begin
            rd_idx_d = CW'(top_q) + CW'(1);
            state_d  = ST_SHIFT;
          end else begin
            state_d = ST_RESULT;
          end
        end
      end

      ST_SHIFT: begin
        // Move each entry above the removed one down by one place
        if (issue) begin
          ram_re    = 1'b1;
          rd_idx_d  = rd_idx_q + CW'(1);
          rd_vld_d  = 1'b1;
          cmp_idx_d = rd_idx_q[AW-1:0];
        end
        if (rd_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_q - AW'(1);
          ram_wdata = ram_rdata;
        end
        if (!issue && !rd_vld_q) begin
          count_d = count_q - CW'(1);
          state_d = ST_RESULT;
        end
      end

      ST_RESULT: begin
        // Load the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          out_valid_d   = 1'b1;
          match_count_d = RES_W'(hits_q);
          found_d       = (hits_q != '0);
          overflow_d    = ovf_q;
          fill_level_d  = RES_W'(count_q);
          state_d       = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result payload
  always_ff @(posedge clk_i) begin
    hits_q        <= hits_d;
    rd_idx_q      <= rd_idx_d;
    cmp_idx_q     <= cmp_idx_d;
    top_q         <= top_d;
    ovf_q         <= ovf_d;
    remove_q      <= remove_d;
    value_q       <= value_d;
    match_count_q <= match_count_d;
    found_q       <= found_d;
    overflow_q    <= overflow_d;
    fill_level_q  <= fill_level_d;
  end

  assign out_valid_o   = out_valid_q;
  assign match_count_o = match_count_q;
  assign found_o       = found_q;
  assign overflow_o    = overflow_q;
  assign fill_level_o  = fill_level_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  a_no_rw_collide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("read and write hit the same entry in one cycle");

  a_idle_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !rd_vld_q)
    else $error("read still in flight while accepting");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && (mode_i == MODE_PUSH) && (count_q != CW'(STACK_DEPTH)))
      |=> (count_q == $past(count_q) + CW'(1)))
    else $error("push did not advance the entry count");
`endif

endmodule

`default_nettype wire

/* bench/tb_stack_with_match_count_and_remove.sv */
// Self-checking bench for the LIFO stack with match count and topmost-match removal.
`default_nettype none

module tb_stack_with_match_count_and_remove;
  import swmc_pkg::*;

  localparam int unsigned DEPTH       = 64;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;
  localparam int          QUIET_LIMIT = 4000;
  localparam int          HOLD_CYCLES = 300;
  localparam int          MAX_REPORTS = 10;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] val;
  } stack_op_t;

  typedef struct packed {
    logic [RES_W-1:0] match_count;
    logic             found;
    logic             overflow;
    logic [RES_W-1:0] fill_level;
  } stack_res_t;

  logic                     clk         = 1'b0;
  logic                     rst_n       = 1'b0;
  logic                     in_valid    = 1'b0;
  logic                     in_ready;
  logic [1:0]               mode        = '0;
  logic signed [DATA_W-1:0] value       = '0;
  logic                     out_valid;
  logic                     out_ready   = 1'b0;
  logic [RES_W-1:0]         match_count;
  logic                     found;
  logic                     overflow;
  logic [RES_W-1:0]         fill_level;

  stack_op_t   op_queue[$];
  stack_res_t  result_queue[$];
  logic [31:0] shadow_mem[DEPTH];
  int          shadow_cnt  = 0;
  logic [31:0] val_pool[4];
  int          src_idle_pct  = 0;
  int          snk_stall_pct = 0;
  bit          hold_req      = 1'b0;
  logic        sink_hold     = 1'b0;
  int          errors        = 0;
  int          quiet_cycles  = 0;

  stack_with_match_count_and_remove #(.STACK_DEPTH(DEPTH)) uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .mode_i        (mode),
    .value_i       (value),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .match_count_o (match_count),
    .found_o       (found),
    .overflow_o    (overflow),
    .fill_level_o  (fill_level)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one operation to the shadow stack and return the result it yields
  function automatic stack_res_t apply_stack_op(logic [1:0] op, logic [31:0] val);
    stack_res_t r;
    int hits;
    int top_idx;
    r       = '0;
    hits    = 0;
    top_idx = 0;
    case (op) inside
      MODE_PUSH: begin
        if (shadow_cnt >= DEPTH) begin
          r.overflow = 1'b1;
        end else begin
          shadow_mem[shadow_cnt] = val;
          shadow_cnt++;
        end
      end
      MODE_COUNT, MODE_REMOVE: begin
        for (int k = 0; k < shadow_cnt; k++) begin
          if (shadow_mem[k] == val) begin
            hits++;
            top_idx = k;
          end
        end
        r.found       = (hits != 0);
        r.match_count = hits[RES_W-1:0];
        // Close the gap left by the topmost match
        if (op == MODE_REMOVE && hits != 0) begin
          for (int k = top_idx; k + 1 < shadow_cnt; k++) shadow_mem[k] = shadow_mem[k + 1];
          shadow_cnt--;
        end
      end
      default: ;
    endcase
    r.fill_level = shadow_cnt[RES_W-1:0];
    return r;
  endfunction

  function automatic void add_op(logic [1:0] op, logic [31:0] val);
    stack_op_t t;
    t.op  = op;
    t.val = val;
    op_queue.push_back(t);
  endfunction

  // Pick a value biased toward the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return VAL_MIN;
      1: return VAL_MAX;
      2: return 32'h0;
      3: return 32'hffff_ffff;
      4: return 32'($urandom_range(7));
      default: return $urandom();
    endcase
  endfunction

  // Mostly hit values already in use, sometimes miss
  function automatic logic [31:0] search_value();
    if ($urandom_range(99) < 80) return val_pool[$urandom_range(3)];
    return pick_value();
  endfunction

  function automatic void refresh_pool();
    val_pool[$urandom_range(3)] = pick_value();
    val_pool[$urandom_range(3)] = pick_value();
  endfunction

  function automatic void fill_burst(int n);
    for (int i = 0; i < n; i++) add_op(MODE_PUSH, search_value());
  endfunction

  function automatic void mixed_burst(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 35) add_op(MODE_PUSH, search_value());
      else if (r < 65) add_op(MODE_COUNT, search_value());
      else if (r < 95) add_op(MODE_REMOVE, search_value());
      else add_op(MODE_UNUSED, $urandom());
    end
  endfunction

  function automatic void drain_burst(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 85) add_op(MODE_REMOVE, search_value());
      else add_op(MODE_COUNT, search_value());
    end
  endfunction

  // Queue bursts of random operations until at least n more are pending
  function automatic void gen_random(int n);
    int target;
    int kind;
    target = op_queue.size() + n;
    while (op_queue.size() < target) begin
      refresh_pool();
      kind = $urandom_range(9);
      if (kind < 2) fill_burst($urandom_range(70, 20));
      else if (kind < 8) mixed_burst($urandom_range(24, 8));
      else drain_burst($urandom_range(40, 10));
    end
  endfunction

  // Wait until every transaction went in and every result came out
  task automatic wait_idle();
    while (op_queue.size() != 0 || in_valid || result_queue.size() != 0) @(negedge clk);
  endtask

  // Offer queued transactions; predict each one as it is accepted
  always @(posedge clk or negedge rst_n) begin
    stack_op_t t;
    if (!rst_n) begin
      in_valid <= 1'b0;
      mode     <= '0;
      value    <= '0;
    end else begin
      if (in_valid && in_ready) result_queue.push_back(apply_stack_op(mode, value));
      if (!in_valid || in_ready) begin
        if (op_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          t = op_queue.pop_front();
          in_valid <= 1'b1;
          mode     <= t.op;
          value    <= t.val;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check each accepted result against the oldest prediction
  always @(posedge clk or negedge rst_n) begin
    stack_res_t exp_r;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (result_queue.size() == 0) begin
          errors++;
          if (errors <= MAX_REPORTS)
            $display("unexpected result: count=%0d found=%0b ovf=%0b fill=%0d",
                     match_count, found, overflow, fill_level);
        end else begin
          exp_r = result_queue.pop_front();
          if (match_count !== exp_r.match_count || found !== exp_r.found ||
              overflow !== exp_r.overflow || fill_level !== exp_r.fill_level) begin
            errors++;
            if (errors <= MAX_REPORTS)
              $display({"mismatch: exp count=%0d found=%0b ovf=%0b fill=%0d,",
                        " got count=%0d found=%0b ovf=%0b fill=%0d"},
                       exp_r.match_count, exp_r.found, exp_r.overflow, exp_r.fill_level,
                       match_count, found, overflow, fill_level);
          end
        end
      end
      out_ready <= !sink_hold && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Hold off the result channel for a long stretch on request
  initial begin
    forever begin
      wait (hold_req);
      sink_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      sink_hold <= 1'b0;
      hold_req = 1'b0;
    end
  end

  // End the run when no transaction moves while work is outstanding
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (op_queue.size() == 0 && !in_valid && result_queue.size() == 0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_stack_with_match_count_and_remove: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    val_pool[0] = VAL_MIN;
    val_pool[1] = VAL_MAX;
    val_pool[2] = 32'h0;
    val_pool[3] = 32'h5;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty stack, extremes, every operation, misses and the unused code
    add_op(MODE_COUNT, 32'h0);
    add_op(MODE_REMOVE, 32'h5);
    add_op(MODE_UNUSED, 32'h0);
    add_op(MODE_PUSH, VAL_MIN);
    add_op(MODE_PUSH, VAL_MAX);
    add_op(MODE_PUSH, 32'h0);
    add_op(MODE_PUSH, 32'hffff_ffff);
    add_op(MODE_PUSH, VAL_MAX);
    add_op(MODE_PUSH, 32'h7);
    add_op(MODE_PUSH, VAL_MAX);
    add_op(MODE_COUNT, VAL_MAX);
    add_op(MODE_COUNT, VAL_MIN);
    add_op(MODE_COUNT, 32'h7fff_fffe);
    add_op(MODE_REMOVE, VAL_MAX);
    add_op(MODE_REMOVE, VAL_MAX);
    add_op(MODE_REMOVE, VAL_MIN);
    add_op(MODE_REMOVE, 32'd12345);
    add_op(MODE_UNUSED, VAL_MAX);
    add_op(MODE_COUNT, VAL_MAX);
    add_op(MODE_REMOVE, 32'h7);
    add_op(MODE_REMOVE, 32'hffff_ffff);
    add_op(MODE_REMOVE, 32'h0);
    add_op(MODE_REMOVE, VAL_MAX);
    add_op(MODE_COUNT, 32'hffff_ffff);
    wait_idle();

    // Random, no idling; start by overfilling the stack
    fill_burst(70);
    drain_burst(20);
    gen_random(60);
    wait_idle();

    // Random with a sparse sender
    src_idle_pct  = 76;
    snk_stall_pct = 0;
    gen_random(130);
    wait_idle();

    // Random with a slow receiver
    src_idle_pct  = 0;
    snk_stall_pct = 76;
    gen_random(130);
    wait_idle();

    // Random with both sides idling
    src_idle_pct  = 23;
    snk_stall_pct = 23;
    gen_random(130);
    wait_idle();

    // Back-pressure: block the receiver while the sender keeps offering
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    hold_req      = 1'b1;
    fill_burst(10);
    mixed_burst(30);
    wait_idle();

    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("tb_stack_with_match_count_and_remove: clean");
    end else begin
      $display("tb_stack_with_match_count_and_remove: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
